[rtl/entry_ring_with_offset_lookup_macros.svh]
// ----------------------------------------------------------------------------
// Entry ring assertion macros
// Shared concurrent assertion forms for the entry ring checker.
// ----------------------------------------------------------------------------
`ifndef ENTRY_RING_WITH_OFFSET_LOOKUP_MACROS_SVH
`define ENTRY_RING_WITH_OFFSET_LOOKUP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ERL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ERL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/erl_pkg.sv]
// ----------------------------------------------------------------------------
// erl_pkg
// Types, widths and command codes shared by the entry ring modules.
// ----------------------------------------------------------------------------
package erl_pkg;

	localparam int DEPTH_DEF = 16;
	localparam int DEPTH_MAX = 256;

	localparam int SIZE_W   = 16;
	localparam int HANDLE_W = 32;
	localparam int OFS_W    = 20;
	localparam int SLOT_W   = 4;
	// running sum only passes on while it stays at or below the offset
	localparam int SUM_W    = OFS_W + 1;
	// entry count, up to DEPTH_MAX
	localparam int CNT_W    = $clog2(DEPTH_MAX + 1);

	localparam logic CMD_ADD  = 1'b0;
	localparam logic CMD_FIND = 1'b1;

	typedef struct packed {
		logic                cmd;
		logic [SIZE_W-1:0]   entry_size;
		logic [HANDLE_W-1:0] entry_handle;
		logic [OFS_W-1:0]    lookup_pos;
	} req_t;

	typedef struct packed {
		logic                ok;
		logic [SLOT_W-1:0]   found_slot;
		logic [HANDLE_W-1:0] found_handle;
		logic [SIZE_W-1:0]   byte_in_entry;
		logic                evicted;
		logic [HANDLE_W-1:0] evicted_handle;
	} rsp_t;

	// search token walking the ring
	typedef struct packed {
		logic             valid;
		logic [SUM_W-1:0] run_sum;
		logic [CNT_W-1:0] rem;
	} tok_t;

	// per-cell search outcome, all zero unless this cell ends the walk
	typedef struct packed {
		logic                done;
		logic                hit;
		logic [SLOT_W-1:0]   slot;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   byte_ofs;
	} cell_rsp_t;

endpackage

[rtl/erl_cell.sv]
// ----------------------------------------------------------------------------
// erl_cell
// One ring slot: stores an entry and evaluates the search token passing by.
// ----------------------------------------------------------------------------
module erl_cell #(
	parameter int DEPTH = erl_pkg::DEPTH_DEF,
	parameter int INDEX = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [$clog2(DEPTH)-1:0]      wr_ptr,
	input  logic [erl_pkg::SIZE_W-1:0]    wr_size,
	input  logic [erl_pkg::HANDLE_W-1:0]  wr_handle,
	input  logic                          inject,
	input  logic [$clog2(DEPTH)-1:0]      start_ptr,
	input  erl_pkg::tok_t                 start_tok,
	input  erl_pkg::tok_t                 tok_in,
	input  logic [erl_pkg::OFS_W-1:0]     offset,
	output erl_pkg::tok_t                 tok_out,
	output erl_pkg::cell_rsp_t            cell_rsp,
	output logic [erl_pkg::HANDLE_W-1:0]  ev_handle
);
	import erl_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] MY_IDX = PTR_W'(INDEX);

	logic [SIZE_W-1:0]   size_q;
	logic [HANDLE_W-1:0] handle_q;
	tok_t                tok_q;
	logic                wr_here;
	logic [SUM_W-1:0]    after;
	logic [SUM_W-1:0]    ofs_ext;
	logic                in_range;

	assign wr_here = wr_en && (wr_ptr == MY_IDX);

	// entry storage, no reset
	always_ff @(posedge clk) begin
		if (wr_here) begin
			size_q   <= wr_size;
			handle_q <= wr_handle;
		end
	end

	// token register: injected at the oldest slot, else taken from the left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (inject && (start_ptr == MY_IDX)) begin
			tok_q <= start_tok;
		end else begin
			tok_q <= tok_in;
		end
	end

	// old handle at the write slot, used when a full ring overwrites it
	assign ev_handle = wr_here ? handle_q : '0;

	// evaluate token against this entry
	assign ofs_ext  = SUM_W'(offset);
	assign after    = tok_q.run_sum + SUM_W'(size_q);
	assign in_range = ofs_ext < after;

	always_comb begin
		tok_out  = '0;
		cell_rsp = '0;
		if (tok_q.valid) begin
			if (tok_q.rem == '0) begin
				cell_rsp.done = 1'b1;
			end else if (in_range) begin
				cell_rsp.done     = 1'b1;
				cell_rsp.hit      = 1'b1;
				cell_rsp.slot     = SLOT_W'(INDEX);
				cell_rsp.handle   = handle_q;
				cell_rsp.byte_ofs = SIZE_W'(ofs_ext - tok_q.run_sum);
			end else begin
				tok_out.valid   = 1'b1;
				tok_out.run_sum = after;
				tok_out.rem     = tok_q.rem - CNT_W'(1);
			end
		end
	end

endmodule

[rtl/entry_ring_with_offset_lookup.sv]
// ----------------------------------------------------------------------------
// entry_ring_with_offset_lookup
// Ring of DEPTH (handle, size) entries with overwrite-oldest adds and
// oldest-first character offset lookup.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) takes one command per transfer:
//   an add stores an entry, a find locates a character offset. rsp channel
//   (rsp_valid/rsp_stall/rsp) returns exactly one result per command.
// Command flow:
//   An add returns its result in the cycle after the transfer; a new command
//   may follow in the next cycle unless the receiver stalls. A find injects
//   a search token at the oldest slot; the token moves one cell per cycle
//   through the row of cells until a cell ends the walk with a hit or, after
//   all stored entries, a miss. The request side stalls while a search walks
//   the ring.
// Reset:
//   arst_n clears the pointers, the full flag, the token, the busy flag and
//   the result valid; the ring reads as empty. Entry storage is not cleared.
// Receiver stall:
//   The result is held in the output register; a further command is taken
//   only once that register is free or being emptied in the same cycle.
// ----------------------------------------------------------------------------
module entry_ring_with_offset_lookup #(
	parameter int DEPTH = erl_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  erl_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output erl_pkg::rsp_t rsp
);
	import erl_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic             full_q;
	logic             busy_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	rsp_t             rsp_d;
	logic [OFS_W-1:0] ofs_q;

	logic             accept, is_add, add_ok, is_find;
	logic [PTR_W-1:0] wr_nxt, rd_nxt;
	logic [CNT_W-1:0] cnt;
	tok_t             start_tok;

	tok_t                tok_pass [DEPTH];
	cell_rsp_t           crsp     [DEPTH];
	logic [HANDLE_W-1:0] ev_h     [DEPTH];

	cell_rsp_t           crsp_or;
	logic [HANDLE_W-1:0] ev_or;

	// handshake
	assign req_stall = busy_q | (rsp_valid_q & rsp_stall);
	assign accept    = req_valid & ~req_stall;
	assign is_add    = accept && (req.cmd == CMD_ADD);
	assign is_find   = accept && (req.cmd == CMD_FIND);
	assign add_ok    = is_add && (req.entry_size != '0) && (req.entry_handle != '0);

	// pointer stepping
	assign wr_nxt = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
	assign rd_nxt = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);

	// stored entry count
	always_comb begin
		if (full_q) begin
			cnt = CNT_W'(DEPTH);
		end else if (wr_ptr_q >= rd_ptr_q) begin
			cnt = CNT_W'(wr_ptr_q) - CNT_W'(rd_ptr_q);
		end else begin
			cnt = CNT_W'(DEPTH) + CNT_W'(wr_ptr_q) - CNT_W'(rd_ptr_q);
		end
	end

	assign start_tok = '{valid: 1'b1, run_sum: '0, rem: cnt};

	// row of cells, token handed from cell i-1 to cell i, the last cell feeding cell 0
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		erl_cell #(
			.DEPTH (DEPTH),
			.INDEX (gi)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.wr_en     (add_ok),
			.wr_ptr    (wr_ptr_q),
			.wr_size   (req.entry_size),
			.wr_handle (req.entry_handle),
			.inject    (is_find),
			.start_ptr (rd_ptr_q),
			.start_tok (start_tok),
			.tok_in    (tok_pass[(gi + DEPTH - 1) % DEPTH]),
			.offset    (ofs_q),
			.tok_out   (tok_pass[gi]),
			.cell_rsp  (crsp[gi]),
			.ev_handle (ev_h[gi])
		);
	end

	// combine cell outcomes; at most one cell reports at a time
	always_comb begin
		crsp_or = '0;
		ev_or   = '0;
		for (int i = 0; i < DEPTH; i++) begin
			crsp_or = crsp_or | crsp[i];
			ev_or   = ev_or | ev_h[i];
		end
	end

	// ring pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			full_q   <= 1'b0;
		end else if (add_ok) begin
			wr_ptr_q <= wr_nxt;
			if (full_q) begin
				rd_ptr_q <= rd_nxt;
			end
			full_q <= (wr_nxt == (full_q ? rd_nxt : rd_ptr_q));
		end
	end

	// offset held for the walk
	always_ff @(posedge clk) begin
		if (is_find) begin
			ofs_q <= req.lookup_pos;
		end
	end

	// search state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			priority if (is_find) begin
				busy_q <= 1'b1;
				if (!rsp_stall) begin
					rsp_valid_q <= 1'b0;
				end
			end else if (is_add) begin
				rsp_valid_q <= 1'b1;
			end else if (busy_q && crsp_or.done) begin
				busy_q      <= 1'b0;
				rsp_valid_q <= 1'b1;
			end else begin
				if (!rsp_stall) begin
					rsp_valid_q <= 1'b0;
				end
			end
		end
	end

	// next result payload
	always_comb begin
		rsp_d = '0;
		if (is_add) begin
			rsp_d.ok             = add_ok;
			rsp_d.evicted        = add_ok & full_q;
			rsp_d.evicted_handle = (add_ok & full_q) ? ev_or : '0;
		end else begin
			rsp_d.ok            = crsp_or.hit;
			rsp_d.found_slot    = crsp_or.slot;
			rsp_d.found_handle  = crsp_or.handle;
			rsp_d.byte_in_entry = crsp_or.byte_ofs;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (is_add || (busy_q && crsp_or.done)) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/erl_checker.sv]
// ----------------------------------------------------------------------------
// erl_checker
// Port-level checks on the entry ring, bound to the top level.
// ----------------------------------------------------------------------------
`include "entry_ring_with_offset_lookup_macros.svh"

module erl_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input erl_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input erl_pkg::rsp_t rsp
);
	import erl_pkg::*;

	logic lookup_zero;
	logic evict_zero;

	// lookup fields and eviction fields all clear
	assign lookup_zero = (rsp.found_slot == '0) && (rsp.found_handle == '0) &&
	                     (rsp.byte_in_entry == '0);
	assign evict_zero  = !rsp.evicted && (rsp.evicted_handle == '0);

	// stalled command does not change
	`ERL_ASSERT_NEXT(a_req_hold, clk, arst_n, req_valid && req_stall, req_valid && $stable(req), "command changed while stalled")

	// held result does not change under stall
	`ERL_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "result changed while stalled")

	// a rejected add or a miss carries only zeros
	`ERL_ASSERT_NOW(a_fail_zero, clk, arst_n, rsp_valid && !rsp.ok, lookup_zero && evict_zero, "failed result has nonzero fields")

	// an eviction is an accepted add with no lookup fields
	`ERL_ASSERT_NOW(a_evict_add, clk, arst_n, rsp_valid && rsp.evicted, rsp.ok && rsp.evicted_handle != '0 && lookup_zero, "eviction result malformed")

	// evicted handle only reported with an eviction
	`ERL_ASSERT_NOW(a_evict_handle, clk, arst_n, rsp_valid && !rsp.evicted, rsp.evicted_handle == '0, "evicted handle without eviction")

endmodule

bind entry_ring_with_offset_lookup erl_checker u_erl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
